[src/i2cbe_pkg.sv]
package i2cbe_pkg;

   localparam int unsigned TICK_W     = 16;
   localparam int unsigned PHASE_W    = 5;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd100;

   // write and read bytes: 16 data phases, then two ACK phases
   localparam logic [PHASE_W-1:0] DATA_PHASES = 5'd16;
   localparam logic [PHASE_W-1:0] ACK_HI_PHASE = 5'd17;
   localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = 5'd15;

   // register index, taken from the word address
   localparam logic REG_PHASE_TICKS = 1'b0;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_START  = 3'd1,
      ACT_RSTART = 3'd2,
      ACT_STOP   = 3'd3,
      ACT_WRITE  = 3'd4,
      ACT_READ   = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_received;
      logic       rejected;
   } rsp_type;

   // classified word handed from the front to the back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } item_type;

   function automatic logic [PHASE_W-1:0] phase_count(cmd_type c);
      logic [PHASE_W-1:0] n;
      unique case (c)
         ACT_START:  n = 5'd2;
         ACT_RSTART: n = 5'd5;
         ACT_STOP:   n = 5'd3;
         ACT_WRITE:  n = 5'd18;
         ACT_READ:   n = 5'd18;
         default:    n = 5'd1;
      endcase
      return n;
   endfunction

endpackage

[src/i2cbe_front.sv]
module i2cbe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2cbe_pkg::req_type req_data,
   output logic               q_valid,
   input  logic               q_ready,
   output i2cbe_pkg::item_type q_item
);
   import i2cbe_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    cmd_dec;

   // undefined action codes count as a plain tick
   always_comb begin
      unique case (req_data.action)
         3'd1:    cmd_dec = ACT_START;
         3'd2:    cmd_dec = ACT_RSTART;
         3'd3:    cmd_dec = ACT_STOP;
         3'd4:    cmd_dec = ACT_WRITE;
         3'd5:    cmd_dec = ACT_READ;
         default: cmd_dec = ACT_TICK;
      endcase
   end

   assign slot_in = '{cmd: cmd_dec, tx_byte: req_data.tx_byte,
                      ack_to_send: req_data.ack_to_send, sda_in: req_data.sda_in};

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

[src/i2cbe_back.sv]
module i2cbe_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [i2cbe_pkg::TICK_W-1:0]   phase_ticks,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  i2cbe_pkg::item_type            q_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output i2cbe_pkg::rsp_type             rsp_data
);
   import i2cbe_pkg::*;

   cmd_type            active_ff, active_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [7:0]         shift_ff, shift_in;
   logic               ack_latch_ff, ack_latch_in;
   logic               send_ack_ff, send_ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               oe_ff, oe_in;
   logic [7:0]         rx_hold_ff, rx_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               step, begin_cmd, rej;
   cmd_type            cmd_eff;
   logic [PHASE_W-1:0] ph, ph_inc;
   logic [TICK_W-1:0]  tick_eff, pt;
   logic [7:0]         shift_eff;
   logic               send_ack_eff;
   logic               last_tick, done;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign step    = q_valid && q_ready;

   // a command is taken only while idle, and this tick is its first
   always_comb begin
      begin_cmd    = (active_ff == ACT_TICK) && (q_item.cmd != ACT_TICK);
      rej          = (active_ff != ACT_TICK) && (q_item.cmd != ACT_TICK);
      cmd_eff      = begin_cmd ? q_item.cmd : active_ff;
      ph           = begin_cmd ? '0 : phase_ff;
      tick_eff     = begin_cmd ? '0 : tick_ff;
      send_ack_eff = (begin_cmd && q_item.cmd == ACT_READ) ? q_item.ack_to_send
                                                           : send_ack_ff;
      if (begin_cmd && q_item.cmd == ACT_WRITE) begin
         shift_eff = q_item.tx_byte;
      end else if (begin_cmd && q_item.cmd == ACT_READ) begin
         shift_eff = '0;
      end else begin
         shift_eff = shift_ff;
      end
      pt        = (phase_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
      last_tick = ({1'b0, tick_eff} + {{TICK_W{1'b0}}, 1'b1}) >= {1'b0, pt};
      ph_inc    = ph + 5'd1;
   end

   // next state: phase sequencing and end-of-phase actions
   always_comb begin
      active_in    = cmd_eff;
      phase_in     = ph;
      tick_in      = tick_eff;
      shift_in     = shift_eff;
      ack_latch_in = ack_latch_ff;
      rx_hold_in   = rx_hold_ff;
      done         = 1'b0;
      if (cmd_eff != ACT_TICK) begin
         if (last_tick) begin
            tick_in  = '0;
            phase_in = ph_inc;
            if (ph < DATA_PHASES && ph[0]) begin
               if (cmd_eff == ACT_WRITE) begin
                  shift_in = {shift_eff[6:0], 1'b0};
               end else if (cmd_eff == ACT_READ) begin
                  shift_in = {shift_eff[6:0], q_item.sda_in};
                  if (ph == LAST_BIT_PHASE) begin
                     rx_hold_in = {shift_eff[6:0], q_item.sda_in};
                  end
               end
            end else if (ph == ACK_HI_PHASE && cmd_eff == ACT_WRITE) begin
               ack_latch_in = q_item.sda_in;
            end
            if (ph_inc >= phase_count(cmd_eff)) begin
               active_in = ACT_TICK;
               phase_in  = '0;
               done      = 1'b1;
            end
         end else begin
            tick_in = tick_eff + {{(TICK_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // line levels for the current phase; idle keeps them
   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      oe_in  = oe_ff;
      unique case (cmd_eff)
         ACT_START: begin
            scl_in = (ph == '0);
            sda_in = 1'b0;
            oe_in  = 1'b1;
         end
         ACT_RSTART: begin
            priority if (ph == 5'd0) begin
               scl_in = 1'b0;
            end else if (ph == 5'd1) begin
               scl_in = 1'b0; sda_in = 1'b1; oe_in = 1'b1;
            end else if (ph == 5'd2) begin
               scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b1;
            end else if (ph == 5'd3) begin
               scl_in = 1'b1; sda_in = 1'b0; oe_in = 1'b1;
            end else begin
               scl_in = 1'b0; sda_in = 1'b0; oe_in = 1'b1;
            end
         end
         ACT_STOP: begin
            priority if (ph == 5'd0) begin
               scl_in = 1'b0;
            end else if (ph == 5'd1) begin
               scl_in = 1'b1; sda_in = 1'b0; oe_in = 1'b1;
            end else begin
               scl_in = 1'b1; sda_in = 1'b1; oe_in = 1'b1;
            end
         end
         ACT_WRITE: begin
            scl_in = ph[0];
            if (ph < DATA_PHASES) begin
               sda_in = shift_eff[7];
               oe_in  = 1'b1;
            end else begin
               oe_in = 1'b0;
            end
         end
         ACT_READ: begin
            scl_in = ph[0];
            if (ph < DATA_PHASES) begin
               oe_in = 1'b0;
            end else begin
               sda_in = send_ack_eff;
               oe_in  = 1'b1;
            end
         end
         default: begin
            scl_in = scl_ff;
         end
      endcase
   end

   always_comb begin
      rsp_in = '{scl: scl_in, sda_out: oe_in & sda_in, sda_oe: oe_in,
                 busy_res: (active_in != ACT_TICK), done_res: done,
                 rx_byte: rx_hold_in, ack_received: ack_latch_in, rejected: rej};
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACT_TICK;
         phase_ff     <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         ack_latch_ff <= 1'b0;
         send_ack_ff  <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         oe_ff        <= 1'b0;
         rx_hold_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            active_ff    <= active_in;
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            shift_ff     <= shift_in;
            ack_latch_ff <= ack_latch_in;
            send_ack_ff  <= send_ack_eff;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            oe_ff        <= oe_in;
            rx_hold_ff   <= rx_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/i2c_master_bit_engine_core.sv]
// Tick-driven I2C master bit engine.
// Each word on the req channel is one timebase tick: it carries the sampled
// SDA level and may start a command (start, repeated start, stop, write byte,
// read byte). Every tick yields exactly one word on the rsp channel with the
// SCL/SDA levels to drive, busy/done flags, the last received byte, the last
// slave ACK and a flag for commands dropped because the engine was busy.
// Each SCL/SDA phase lasts phase_ticks ticks, set through the APB register at
// byte address 0 (reset value 100, zero acts as one); write it only while idle.
// A two-entry queue parts the request side from the sequencer, and a result
// register parts the sequencer from the rsp side. An accepted tick is held in
// a queue entry, then in the result register, before rsp_valid rises. One tick
// per cycle passes while the receiver does not stall; the sequencer step
// updates the phase state every tick. When the receiver stalls, the result
// register holds and the queue fills; req_ready falls once both queue entries
// are taken, no tick is ever lost. Reset empties the queue and the result
// register, leaves the engine idle with SCL and SDA high and SDA released.
module i2c_master_bit_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  i2cbe_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output i2cbe_pkg::rsp_type                   rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [i2cbe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [i2cbe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [i2cbe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);
   import i2cbe_pkg::*;

   logic [TICK_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic              csr_wr;
   logic              q_valid, q_ready;
   item_type          q_item;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      if (csr_wr && paddr[2] == REG_PHASE_TICKS) begin
         phase_ticks_in = pwdata[TICK_W-1:0];
      end
      if (paddr[2] == REG_PHASE_TICKS) begin
         prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, phase_ticks_ff};
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   i2cbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   i2cbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .phase_ticks (phase_ticks_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   a_released_sda_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sda_oe |-> !rsp_data.sda_out)
      else $error("sda_out high while SDA released");

   a_step_gives_word: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> rsp_valid)
      else $error("sequencer step produced no result word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("channels not empty after reset");

endmodule
